[rtl/cdsm_pkg.sv]
// Package for the compressed DFA string matcher.
// Item structs, table and status codes, control state type. No dependencies.
`timescale 1ns / 1ps
package cdsm_pkg;

  localparam int StatesMaxDef = 1024;
  localparam int RowsMaxDef   = 64;
  localparam int SymsPerRow   = 255;
  localparam int OutValW      = 16;
  localparam int OutEntryW    = OutValW + 1;
  localparam int CfgIdxW      = 8;
  localparam int CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] CFG_NUM_STATES     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_COMPRESSED = 8'd1;

  localparam logic ACT_MATCH = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  localparam logic [7:0] SYM_END = 8'd0;

  typedef enum logic [2:0] {
    TBL_DEFAULT = 3'd0,
    TBL_BASE    = 3'd1,
    TBL_NEXT    = 3'd2,
    TBL_CHECK   = 3'd3,
    TBL_OUTPUT  = 3'd4
  } tbl_sel_e;

  typedef enum logic [1:0] {
    WR_OK        = 2'd0,
    WR_BAD_INDEX = 2'd1,
    WR_BAD_VALUE = 2'd2
  } wr_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYM1,
    ST_SYM2,
    ST_EOS1
  } ctrl_state_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  symbol;
    logic [2:0]  table_select;
    logic [13:0] entry_index;
    logic [15:0] entry_value;
    logic        entry_invalid;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        matched;
    logic [15:0] match_output;
    logic [1:0]  write_status;
  } out_item_t;

  typedef struct packed {
    wr_status_e status;
    logic       we_default;
    logic       we_base;
    logic       we_next;
    logic       we_check;
    logic       we_output;
  } wr_ctl_t;

endpackage

[rtl/compressed_dfa_string_matcher.sv]
// Top level of the compressed DFA string matcher.
// Depends on cdsm_pkg, cdsm_ram and cdsm_wr_check.
`timescale 1ns / 1ps
//
// Usage:
//   in channel  (in_valid_i/in_ready_o, in_data_i): match symbols, end-of-string
//   markers (symbol 0) and table write items.
//   out channel (out_valid_o/out_ready_i, out_data_o): one item per write
//   (acknowledge with status) and per end of string (match and output value).
//   cfg channel (cfg_valid_i/cfg_ready_o): num_states (index 0) and
//   num_compressed (index 1), saturated into their legal range; always ready.
// Operation:
//   A symbol reads base/default by state, then next/check by row index; the new
//   state is forwarded to the state read address so the next item can enter
//   during SYM2. A write's ack is registered on the accepting edge. An end of
//   string reads the output table at the accepting edge, and its result is
//   registered in EOS1.
// Reset: state 0, not dead, num_states 1, num_compressed 1, output empty.
//   Tables are not cleared and must be written before they are read.
// Stall: a result waits in the output register; symbols keep being accepted,
//   items that produce a result wait until the register drains.
module compressed_dfa_string_matcher import cdsm_pkg::*; #(
  parameter int STATES_MAX = StatesMaxDef,
  parameter int ROWS_MAX   = RowsMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int StW     = (STATES_MAX > 1) ? $clog2(STATES_MAX) : 1;
  localparam int RW      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int RowDep  = ROWS_MAX * SymsPerRow;
  localparam int JW      = $clog2(RowDep);
  localparam int NsW     = $clog2(STATES_MAX + 1);
  localparam int NcW     = $clog2(ROWS_MAX + 1);
  localparam int RowsW   = $clog2(RowDep + 1);
  localparam int EntW    = StW + 1;

  ctrl_state_e state_q, state_d;
  logic [StW-1:0]   cs_q, cs_d;
  logic             dead_q, dead_d;
  logic [NsW-1:0]   num_states_q;
  logic [NcW-1:0]   num_comp_q;
  logic [RowsW-1:0] rows_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;
  logic [7:0]       sym_q;
  logic [EntW-1:0]  def_q;

  logic accept, pipe_free, makes_result, slot_ok;
  logic is_write, is_sym, is_eos;
  wr_ctl_t wr_ctl;

  logic [31:0]      idx32, val32;
  logic [StW-1:0]   st_waddr;
  logic [JW-1:0]    row_waddr;
  logic [EntW-1:0]  st_wdata;
  logic [EntW-1:0]  def_rd, nxt_rd, chk_rd;
  logic [RW-1:0]    base_rd;
  logic [OutEntryW-1:0] out_rd;
  logic [31:0]      j32;
  logic [JW-1:0]    j_addr;
  logic             st_re;
  logic             chk_hit;
  logic [EntW-1:0]  nxt_sel;
  logic             nxt_dead;
  logic             eos_hit;

  // Control
  assign is_write     = (in_data_i.action == ACT_WRITE);
  assign is_eos       = !is_write && (in_data_i.symbol == SYM_END);
  assign is_sym       = !is_write && (in_data_i.symbol != SYM_END);
  assign pipe_free    = (state_q == ST_IDLE) || (state_q == ST_SYM2);
  assign makes_result = is_write || is_eos;
  assign slot_ok      = !out_valid_q || out_ready_i;
  assign in_ready_o   = pipe_free && (!makes_result || slot_ok);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE, ST_SYM2: begin
        if (accept) begin
          priority if (is_write) state_d = ST_IDLE;
          else if (is_sym) state_d = ST_SYM1;
          else state_d = ST_EOS1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SYM1: state_d = ST_SYM2;
      ST_EOS1: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= NsW'(1);
      num_comp_q   <= NcW'(1);
      rows_q       <= RowsW'(SymsPerRow);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_idx_i == CFG_NUM_STATES) begin
        if (cfg_data_i == '0) num_states_q <= NsW'(1);
        else if (cfg_data_i > CfgDataW'(STATES_MAX)) num_states_q <= NsW'(STATES_MAX);
        else num_states_q <= cfg_data_i[NsW-1:0];
      end else if (cfg_idx_i == CFG_NUM_COMPRESSED) begin
        if (cfg_data_i == '0) begin
          num_comp_q <= NcW'(1);
          rows_q     <= RowsW'(SymsPerRow);
        end else if (cfg_data_i > CfgDataW'(ROWS_MAX)) begin
          num_comp_q <= NcW'(ROWS_MAX);
          rows_q     <= RowsW'(RowDep);
        end else begin
          num_comp_q <= cfg_data_i[NcW-1:0];
          rows_q     <= RowsW'((cfg_data_i << 8) - cfg_data_i);
        end
      end
    end
  end

  // Table writes
  cdsm_wr_check #(
    .STATES_MAX (STATES_MAX),
    .ROWS_MAX   (ROWS_MAX)
  ) u_wr_check (
    .item_i       (in_data_i),
    .num_states_i (num_states_q),
    .num_comp_i   (num_comp_q),
    .rows_i       (rows_q),
    .ctl_o        (wr_ctl)
  );

  assign idx32     = 32'(in_data_i.entry_index);
  assign val32     = 32'(in_data_i.entry_value);
  assign st_waddr  = idx32[StW-1:0];
  assign row_waddr = idx32[JW-1:0];
  assign st_wdata  = {in_data_i.entry_invalid, val32[StW-1:0]};

  // State-indexed reads use the forwarded state so a new item can enter in SYM2.
  assign st_re = accept && !is_write;

  cdsm_ram #(.Width(EntW), .Depth(STATES_MAX)) u_default_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_write && wr_ctl.we_default),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (cs_d),
    .rdata_o (def_rd)
  );

  cdsm_ram #(.Width(RW), .Depth(STATES_MAX)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_write && wr_ctl.we_base),
    .waddr_i (st_waddr),
    .wdata_i (val32[RW-1:0]),
    .re_i    (st_re),
    .raddr_i (cs_d),
    .rdata_o (base_rd)
  );

  cdsm_ram #(.Width(OutEntryW), .Depth(STATES_MAX)) u_output_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_write && wr_ctl.we_output),
    .waddr_i (st_waddr),
    .wdata_i ({in_data_i.entry_invalid, in_data_i.entry_value}),
    .re_i    (st_re),
    .raddr_i (cs_d),
    .rdata_o (out_rd)
  );

  assign j32    = (32'(base_rd) << 8) - 32'(base_rd) + 32'(sym_q) - 32'd1;
  assign j_addr = j32[JW-1:0];

  cdsm_ram #(.Width(EntW), .Depth(RowDep)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_write && wr_ctl.we_next),
    .waddr_i (row_waddr),
    .wdata_i (st_wdata),
    .re_i    (state_q == ST_SYM1),
    .raddr_i (j_addr),
    .rdata_o (nxt_rd)
  );

  cdsm_ram #(.Width(EntW), .Depth(RowDep)) u_check_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_write && wr_ctl.we_check),
    .waddr_i (row_waddr),
    .wdata_i (st_wdata),
    .re_i    (state_q == ST_SYM1),
    .raddr_i (j_addr),
    .rdata_o (chk_rd)
  );

  always_ff @(posedge clk_i) begin
    if (accept && is_sym) begin
      sym_q <= in_data_i.symbol;
    end
    if (state_q == ST_SYM1) begin
      def_q <= def_rd;
    end
  end

  // Transition
  assign chk_hit  = !chk_rd[StW] && (chk_rd[StW-1:0] == cs_q);
  assign nxt_sel  = chk_hit ? nxt_rd : def_q;
  assign nxt_dead = nxt_sel[StW] || ({1'b0, nxt_sel[StW-1:0]} >= (StW+1)'(STATES_MAX));

  always_comb begin
    cs_d   = cs_q;
    dead_d = dead_q;
    if (state_q == ST_SYM2 && !dead_q) begin
      if (nxt_dead) dead_d = 1'b1;
      else cs_d = nxt_sel[StW-1:0];
    end else if (state_q == ST_EOS1) begin
      cs_d   = '0;
      dead_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= '0;
      dead_q <= 1'b0;
    end else begin
      cs_q   <= cs_d;
      dead_q <= dead_d;
    end
  end

  // Result register
  assign eos_hit = !dead_q && !out_rd[OutValW];

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    priority if (state_q == ST_EOS1) begin
      out_valid_d             = 1'b1;
      out_data_d.kind         = KIND_MATCH;
      out_data_d.matched      = eos_hit;
      out_data_d.match_output = eos_hit ? out_rd[OutValW-1:0] : '0;
      out_data_d.write_status = WR_OK;
    end else if (accept && is_write) begin
      out_valid_d             = 1'b1;
      out_data_d.kind         = KIND_ACK;
      out_data_d.matched      = 1'b0;
      out_data_d.match_output = '0;
      out_data_d.write_status = wr_ctl.status;
    end else begin
      out_data_d = out_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/cdsm_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module cdsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cdsm_wr_check.sv]
// Table write checker: index and value bounds, status code and write enables.
// Depends on cdsm_pkg.
`timescale 1ns / 1ps
module cdsm_wr_check import cdsm_pkg::*; #(
  parameter int STATES_MAX = StatesMaxDef,
  parameter int ROWS_MAX   = RowsMaxDef
) (
  input  in_item_t                                      item_i,
  input  logic [$clog2(STATES_MAX+1)-1:0]               num_states_i,
  input  logic [$clog2(ROWS_MAX+1)-1:0]                 num_comp_i,
  input  logic [$clog2(ROWS_MAX*SymsPerRow+1)-1:0]      rows_i,
  output wr_ctl_t                                       ctl_o
);

  logic [31:0] idx32, val32, ns32, nc32, rows32;
  logic        state_val_ok;

  assign idx32  = 32'(item_i.entry_index);
  assign val32  = 32'(item_i.entry_value);
  assign ns32   = 32'(num_states_i);
  assign nc32   = 32'(num_comp_i);
  assign rows32 = 32'(rows_i);
  assign state_val_ok = item_i.entry_invalid || (val32 < ns32);

  always_comb begin
    ctl_o = '{status: WR_OK, default: 1'b0};
    unique case (item_i.table_select)
      TBL_DEFAULT, TBL_BASE, TBL_OUTPUT: begin
        if (idx32 >= ns32) begin
          ctl_o.status = WR_BAD_INDEX;
        end else if (item_i.table_select == TBL_DEFAULT) begin
          if (!state_val_ok) ctl_o.status = WR_BAD_VALUE;
          else ctl_o.we_default = 1'b1;
        end else if (item_i.table_select == TBL_BASE) begin
          if (item_i.entry_invalid || val32 >= nc32) ctl_o.status = WR_BAD_VALUE;
          else ctl_o.we_base = 1'b1;
        end else begin
          ctl_o.we_output = 1'b1;
        end
      end
      TBL_NEXT, TBL_CHECK: begin
        if (idx32 >= rows32) begin
          ctl_o.status = WR_BAD_INDEX;
        end else if (!state_val_ok) begin
          ctl_o.status = WR_BAD_VALUE;
        end else if (item_i.table_select == TBL_NEXT) begin
          ctl_o.we_next = 1'b1;
        end else begin
          ctl_o.we_check = 1'b1;
        end
      end
      default: begin
        ctl_o.status = WR_BAD_INDEX;
      end
    endcase
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench for compressed_dfa_string_matcher: loads the reachable table entries, then runs
// directed and random string and table-write items against a DFA predictor.
// Depends on cdsm_pkg and the matcher RTL.
`timescale 1ns / 1ps
module tb_top;
  import cdsm_pkg::*;

  localparam int RowEntries    = RowsMaxDef * SymsPerRow;
  localparam int InW           = $bits(in_item_t);
  localparam int HotStates     = 8;
  localparam int HotRows       = 4;
  localparam int NumSyms       = 7;
  localparam int LastState     = StatesMaxDef - 1;
  localparam int LastRow       = RowsMaxDef - 1;
  localparam int ItemsPerPhase = 96;
  localparam int NumPhases     = 6;
  localparam int SettleCycles  = 8;
  localparam int CycleLimit    = 1_000_000;
  localparam logic [16:0] InvWord = 17'h10000;
  localparam logic [2:0] SelUnusedLo = 3'd5;
  localparam logic [2:0] SelUnusedHi = 3'd7;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = CFG_NUM_COMPRESSED + 8'd1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  compressed_dfa_string_matcher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [10:0] n_states = 11'd1;
  logic [6:0]  n_rows = 7'd1;
  logic [9:0]  cur_state = '0;
  bit          str_dead = 1'b0;
  logic [16:0] dflt_tbl  [StatesMaxDef];
  logic [5:0]  base_tbl  [StatesMaxDef];
  logic [16:0] outp_tbl  [StatesMaxDef];
  logic [16:0] next_tbl  [RowEntries];
  logic [16:0] check_tbl [RowEntries];

  in_item_t  item_q[$];
  out_item_t want_q[$];
  int        err_cnt = 0;
  int        cyc_cnt = 0;
  bit        in_acc = 1'b0;
  bit        out_acc = 1'b0;
  bit        idle_on = 1'b0;
  int        in_gap = 0;
  int        out_stall = 0;

  int unsigned ph_states[NumPhases] = '{32'hFFFF_FFFF, 0, 8, 300, 1, 1024};
  int unsigned ph_rows[NumPhases]   = '{65, 0, 8, 3, 64, 64};
  logic [7:0]  sym_set[NumSyms]     = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd128, 8'd254, 8'd255};

  function automatic wr_status_e tbl_write(input in_item_t it);
    logic [16:0] word;
    int rows;
    word = it.entry_invalid ? InvWord : {1'b0, it.entry_value};
    rows = n_rows * SymsPerRow;
    case (it.table_select)
      TBL_DEFAULT, TBL_BASE, TBL_OUTPUT: begin
        if (it.entry_index >= n_states) return WR_BAD_INDEX;
        if (it.table_select == TBL_BASE) begin
          if (it.entry_invalid || it.entry_value >= n_rows) return WR_BAD_VALUE;
          base_tbl[it.entry_index] = it.entry_value[5:0];
        end else if (it.table_select == TBL_DEFAULT) begin
          if (!it.entry_invalid && it.entry_value >= n_states) return WR_BAD_VALUE;
          dflt_tbl[it.entry_index] = word;
        end else begin
          outp_tbl[it.entry_index] = word;
        end
        return WR_OK;
      end
      TBL_NEXT, TBL_CHECK: begin
        if (it.entry_index >= rows) return WR_BAD_INDEX;
        if (!it.entry_invalid && it.entry_value >= n_states) return WR_BAD_VALUE;
        if (it.table_select == TBL_NEXT) next_tbl[it.entry_index] = word;
        else check_tbl[it.entry_index] = word;
        return WR_OK;
      end
      default: return WR_BAD_INDEX;
    endcase
  endfunction

  // returns 1 when the item yields a result
  function automatic bit dfa_step(input in_item_t it, output out_item_t res);
    logic [16:0] chk;
    logic [16:0] nxt;
    logic [16:0] o;
    int j;
    res = '0;
    if (it.action == ACT_WRITE) begin
      res.kind = KIND_ACK;
      res.write_status = tbl_write(it);
      return 1'b1;
    end
    if (it.symbol != SYM_END) begin
      if (!str_dead) begin
        j = base_tbl[cur_state] * SymsPerRow + it.symbol - 1;
        chk = check_tbl[j];
        if (!chk[16] && chk[15:0] == cur_state) nxt = next_tbl[j];
        else nxt = dflt_tbl[cur_state];
        if (nxt[16] || nxt[15:0] >= StatesMaxDef) str_dead = 1'b1;
        else cur_state = nxt[9:0];
      end
      return 1'b0;
    end
    o = outp_tbl[cur_state];
    res.kind = KIND_MATCH;
    if (!str_dead && !o[16]) begin
      res.matched = 1'b1;
      res.match_output = o[15:0];
    end
    cur_state = '0;
    str_dead = 1'b0;
    return 1'b1;
  endfunction

  // only a few states, rows and symbols are reachable
  function automatic int pick_state();
    return ($urandom_range(0, 7) == 0) ? LastState : int'($urandom_range(0, HotStates - 1));
  endfunction

  function automatic int pick_row();
    return ($urandom_range(0, 7) == 0) ? LastRow : int'($urandom_range(0, HotRows - 1));
  endfunction

  function automatic logic [7:0] pick_sym();
    return sym_set[$urandom_range(0, NumSyms - 1)];
  endfunction

  function automatic int hot_j();
    return pick_row() * SymsPerRow + int'(pick_sym()) - 1;
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it = InW'({$urandom, $urandom});
    return it;
  endfunction

  function automatic in_item_t sym_item(input logic [7:0] s);
    in_item_t it;
    it = rand_fields();
    it.action = ACT_MATCH;
    it.symbol = s;
    return it;
  endfunction

  function automatic in_item_t wr_item(input logic [2:0] sel, input int idx, input int val,
                                       input bit inv);
    in_item_t it;
    it = rand_fields();
    it.action = ACT_WRITE;
    it.table_select = sel;
    it.entry_index = 14'(idx);
    it.entry_value = 16'(val);
    it.entry_invalid = inv;
    return it;
  endfunction

  function automatic in_item_t rand_write();
    in_item_t it;
    int lim;
    bit row_tbl;
    it = rand_fields();
    it.action = ACT_WRITE;
    if ($urandom_range(0, 7) == 0) it.table_select = 3'($urandom_range(SelUnusedLo, SelUnusedHi));
    else it.table_select = 3'($urandom_range(int'(TBL_DEFAULT), int'(TBL_OUTPUT)));
    row_tbl = (it.table_select == TBL_NEXT || it.table_select == TBL_CHECK);
    lim = row_tbl ? n_rows * SymsPerRow : n_states;
    case ($urandom_range(0, 3))
      0: it.entry_index = 14'($urandom);
      1: it.entry_index = 14'(lim - $urandom_range(0, 1));
      default: it.entry_index = row_tbl ? 14'(hot_j()) : 14'(pick_state());
    endcase
    lim = (it.table_select == TBL_BASE) ? n_rows : n_states;
    case ($urandom_range(0, 3))
      0: it.entry_value = 16'($urandom);
      1: it.entry_value = 16'(lim - $urandom_range(0, 1));
      default: it.entry_value = 16'($urandom_range(0, HotStates - 1));
    endcase
    it.entry_invalid = ($urandom_range(0, 7) == 0);
    // stored states and rows stay within the loaded part of the tables
    if (!it.entry_invalid) begin
      if ((it.table_select == TBL_DEFAULT || it.table_select == TBL_NEXT) &&
          it.entry_value < n_states && it.entry_value >= HotStates &&
          it.entry_value != LastState)
        it.entry_value = 16'($urandom_range(0, HotStates - 1));
      else if (it.table_select == TBL_BASE && it.entry_value < n_rows &&
               it.entry_value >= HotRows && it.entry_value != LastRow)
        it.entry_value = 16'($urandom_range(0, HotRows - 1));
    end
    return it;
  endfunction

  // sample at the rising edge: check results, then predict accepted items
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t res;
    cyc_cnt++;
    in_acc = in_valid_i && in_ready_o;
    out_acc = out_valid_o && out_ready_i;
    if (out_acc) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d matched=%0d output=%h status=%0d", $time,
                 out_data_o.kind, out_data_o.matched, out_data_o.match_output,
                 out_data_o.write_status);
        err_cnt++;
      end else begin
        want = want_q.pop_front();
        if (out_data_o.kind !== want.kind || out_data_o.matched !== want.matched ||
            out_data_o.match_output !== want.match_output ||
            out_data_o.write_status !== want.write_status) begin
          $display("%0t: mismatch expected kind=%0d matched=%0d output=%h status=%0d", $time,
                   want.kind, want.matched, want.match_output, want.write_status);
          $display("%0t:          actual   kind=%0d matched=%0d output=%h status=%0d", $time,
                   out_data_o.kind, out_data_o.matched, out_data_o.match_output,
                   out_data_o.write_status);
          err_cnt++;
        end
      end
    end
    if (in_acc && dfa_step(in_data_i, res)) want_q.push_back(res);
  end

  // drive at the falling edge
  always @(negedge clk_i) begin
    logic vld;
    vld = in_valid_i && !in_acc;
    if (!vld && item_q.size() != 0) begin
      if (in_gap != 0) begin
        in_gap--;
      end else begin
        in_data_i <= item_q.pop_front();
        vld = 1'b1;
        in_gap = idle_on ? $urandom_range(0, 15) : 0;
      end
    end
    in_valid_i <= vld;
    if (out_acc) out_stall = idle_on ? $urandom_range(0, 15) : 0;
    else if (out_stall != 0) out_stall--;
    out_ready_i <= (out_stall == 0);
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    if (idx == CFG_NUM_STATES)
      n_states = (data == 0) ? 11'd1 : (data > StatesMaxDef) ? 11'(StatesMaxDef) : data[10:0];
    else if (idx == CFG_NUM_COMPRESSED)
      n_rows = (data == 0) ? 7'd1 : (data > RowsMaxDef) ? 7'(RowsMaxDef) : data[6:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (item_q.size() != 0 || in_valid_i || want_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // every reachable entry is written first so no lookup ever hits an unwritten word
  task automatic load_tables();
    int s;
    int r;
    int j;
    for (int k = 0; k <= HotStates; k++) begin
      s = (k == HotStates) ? LastState : k;
      item_q.push_back(wr_item(TBL_DEFAULT, s, pick_state(), $urandom_range(0, 15) == 0));
      item_q.push_back(wr_item(TBL_BASE, s, pick_row(), 1'b0));
      item_q.push_back(wr_item(TBL_OUTPUT, s, $urandom, $urandom_range(0, 3) == 0));
    end
    for (int k = 0; k <= HotRows; k++) begin
      r = (k == HotRows) ? LastRow : k;
      for (int m = 0; m < NumSyms; m++) begin
        j = r * SymsPerRow + int'(sym_set[m]) - 1;
        item_q.push_back(wr_item(TBL_NEXT, j, pick_state(), $urandom_range(0, 15) == 0));
        item_q.push_back(wr_item(TBL_CHECK, j,
                                 ($urandom_range(0, 3) != 0) ? pick_state()
                                                             : int'($urandom_range(0, 1023)),
                                 $urandom_range(0, 15) == 0));
      end
    end
  endtask

  task automatic directed();
    item_q.push_back(wr_item(SelUnusedLo, 0, 0, 1'b0));
    item_q.push_back(wr_item(SelUnusedHi, 16383, 65535, 1'b1));
    item_q.push_back(wr_item(TBL_DEFAULT, 1024, 0, 1'b0));
    item_q.push_back(wr_item(TBL_NEXT, RowEntries, 0, 1'b0));
    item_q.push_back(wr_item(TBL_CHECK, 16383, 0, 1'b0));
    item_q.push_back(wr_item(TBL_DEFAULT, 3, 1024, 1'b0));
    item_q.push_back(wr_item(TBL_DEFAULT, 1023, 65535, 1'b1));
    item_q.push_back(wr_item(TBL_BASE, 0, 0, 1'b1));
    item_q.push_back(wr_item(TBL_BASE, 0, 64, 1'b0));
    item_q.push_back(wr_item(TBL_BASE, 0, 0, 1'b0));
    // state 0, symbol 1 hits row 0 entry 0, whose next state is invalid
    item_q.push_back(wr_item(TBL_CHECK, 0, 0, 1'b0));
    item_q.push_back(wr_item(TBL_NEXT, 0, 0, 1'b1));
    item_q.push_back(sym_item(8'd1));
    item_q.push_back(sym_item(8'd255));
    item_q.push_back(sym_item(SYM_END));
    item_q.push_back(wr_item(TBL_NEXT, 0, 5, 1'b0));
    item_q.push_back(wr_item(TBL_OUTPUT, 5, 65535, 1'b0));
    item_q.push_back(sym_item(8'd1));
    item_q.push_back(sym_item(SYM_END));
    item_q.push_back(wr_item(TBL_OUTPUT, 5, 0, 1'b1));
    item_q.push_back(sym_item(8'd1));
    item_q.push_back(sym_item(SYM_END));
    item_q.push_back(sym_item(SYM_END));
    item_q.push_back(wr_item(TBL_OUTPUT, 1023, 0, 1'b0));
    item_q.push_back(wr_item(TBL_NEXT, RowEntries - 1, 1023, 1'b0));
  endtask

  // mostly whole strings, some with writes mixed in, plus lone writes
  task automatic run_random(input int n_items);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 9) < 3) begin
        item_q.push_back(rand_write());
        cnt++;
      end else begin
        len = $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0) item_q.push_back(rand_write());
          else item_q.push_back(sym_item(pick_sym()));
          cnt++;
        end
        item_q.push_back(sym_item(SYM_END));
        cnt++;
      end
    end
  endtask

  initial begin
    wait (cyc_cnt >= CycleLimit);
    $display("[compressed_dfa_string_matcher] ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    cfg_write(CFG_NUM_STATES, StatesMaxDef);
    cfg_write(CFG_NUM_COMPRESSED, RowsMaxDef);
    idle_on = 1'b0;
    load_tables();
    drain();
    idle_on = 1'b1;
    directed();
    drain();
    for (int ph = 0; ph < NumPhases; ph++) begin
      cfg_write(CFG_NUM_STATES, ph_states[ph]);
      cfg_write(CFG_NUM_COMPRESSED, ph_rows[ph]);
      if (ph == 2) cfg_write(CFG_UNUSED, $urandom);
      idle_on = (ph % 3 != 2);
      run_random(ItemsPerPhase);
      drain();
    end
    if (err_cnt == 0) begin
      $display("[compressed_dfa_string_matcher] OK");
    end else begin
      $display("[compressed_dfa_string_matcher] ERROR");
    end
    $finish;
  end

endmodule
